// ----- hdl/smbios_structure_walker_macros.svh -----
// Assertion macros shared by the walker's checker.
`ifndef SMBIOS_STRUCTURE_WALKER_MACROS_SVH
`define SMBIOS_STRUCTURE_WALKER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SMBSW_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("smbsw: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define SMBSW_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("smbsw: next-cycle check failed");

`endif

// ----- hdl/smbsw_pkg.sv -----
// Shared constants for the SMBIOS structure walker.
package smbsw_pkg;

  localparam int unsigned HdrBytes = 4;

  // walk phases
  localparam logic [1:0] PH_HEADER    = 2'd0;
  localparam logic [1:0] PH_FORMATTED = 2'd1;
  localparam logic [1:0] PH_STRINGS   = 2'd2;
  localparam logic [1:0] PH_STOPPED   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_BROKEN    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_WANTED_TYPE  = 2'd0;
  localparam logic [1:0] REG_TABLE_LENGTH = 2'd1;
  localparam logic [1:0] REG_STRUCT_LIMIT = 2'd2;

endpackage

// ----- hdl/smbios_structure_walker.sv -----
// SMBIOS structure table walker, one table byte per beat.
//
// Takes one table byte per clock cycle whenever the slave side is ready.
// The walk state (offset, header fields, string-set zero tracking)
// updates in the cycle a byte is accepted; a report for a wanted structure,
// a truncated one or a broken entry appears on the master side the next
// cycle from a single output register. The slave side stays ready while that
// register is empty or being drained, so throughput is one byte per cycle
// unless the consumer stalls a pending report. Configuration writes are
// always taken and apply from the next byte; there is no clearing pass.
module smbios_structure_walker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // table bytes in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] start_of_table
  // reports out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] struct_type, [15:8] struct_length,
                                      // [31:16] handle, [47:32] struct_offset,
                                      // [63:48] struct_index
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  // configuration
  logic [7:0]  wanted_q;
  logic [15:0] tlen_q, limit_q;

  // walk state
  logic [15:0] off_q, off_d;
  logic [15:0] start_q, start_d;
  logic [15:0] cnt_q, cnt_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] handle_q, handle_d;
  logic [7:0]  fleft_q, fleft_d;
  logic        lzero_q, lzero_d;
  logic        armed_q, armed_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [1:0]  ostat_q;
  logic [63:0] odata_q;

  logic        in_fire, sof, emit, skip_end, done;
  logic [1:0]  emit_stat;
  logic [7:0]  b;
  logic [15:0] o, k, start_b, cnt_b;
  logic [1:0]  phase_b;
  logic        lzero_b, armed_b;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign sof           = s_axis_tuser[0];
  assign b             = s_axis_tdata;

  always_comb begin
    off_d     = off_q;
    start_d   = start_q;
    cnt_d     = cnt_q;
    phase_d   = phase_q;
    type_d    = type_q;
    len_d     = len_q;
    handle_d  = handle_q;
    fleft_d   = fleft_q;
    lzero_d   = lzero_q;
    armed_d   = armed_q;
    emit      = 1'b0;
    emit_stat = smbsw_pkg::ST_COMPLETE;
    skip_end  = 1'b0;
    done      = 1'b0;
    // a start flag restarts the walk at offset zero
    o         = sof ? 16'd0 : off_q;
    start_b   = sof ? 16'd0 : start_q;
    cnt_b     = sof ? 16'd0 : cnt_q;
    phase_b   = sof ? smbsw_pkg::PH_HEADER : phase_q;
    lzero_b   = sof ? 1'b0 : lzero_q;
    armed_b   = sof ? 1'b0 : armed_q;
    k         = o - start_b;

    if (in_fire) begin
      start_d = start_b;
      cnt_d   = cnt_b;
      phase_d = phase_b;
      lzero_d = lzero_b;
      armed_d = armed_b;
      off_d   = (o == 16'hFFFF) ? o : o + 16'd1;

      if (phase_b != smbsw_pkg::PH_STOPPED && o < tlen_q) begin
        if (phase_b == smbsw_pkg::PH_HEADER) begin
          if (k == 16'd0) begin
            // limit reached or no room left for a header
            if (cnt_b >= limit_q ||
                ({1'b0, start_b} + 17'(smbsw_pkg::HdrBytes)) > {1'b0, tlen_q}) begin
              phase_d  = smbsw_pkg::PH_STOPPED;
              skip_end = 1'b1;
            end else begin
              type_d = b;
            end
          end else if (k == 16'd1) begin
            len_d = b;
          end else if (k == 16'd2) begin
            handle_d = {8'd0, b};
          end else begin
            handle_d = {b, handle_q[7:0]};
            if (len_q < 8'(smbsw_pkg::HdrBytes)) begin
              emit      = 1'b1;
              emit_stat = smbsw_pkg::ST_BROKEN;
              phase_d   = smbsw_pkg::PH_STOPPED;
              skip_end  = 1'b1;
            end else begin
              armed_d = 1'b0;
              lzero_d = 1'b0;
              if (len_q == 8'(smbsw_pkg::HdrBytes)) begin
                phase_d = smbsw_pkg::PH_STRINGS;
              end else begin
                fleft_d = len_q - 8'(smbsw_pkg::HdrBytes);
                phase_d = smbsw_pkg::PH_FORMATTED;
              end
            end
          end
        end else if (phase_b == smbsw_pkg::PH_FORMATTED) begin
          fleft_d = fleft_q - 8'd1;
          if (fleft_d == 8'd0) begin
            phase_d = smbsw_pkg::PH_STRINGS;
            armed_d = 1'b0;
            lzero_d = 1'b0;
          end
        end else begin
          // string set ends at a zero right after a zero of the string area
          if (armed_b && lzero_b && b == 8'd0) begin
            done = 1'b1;
          end else begin
            lzero_d = (b == 8'd0);
            armed_d = 1'b1;
          end
        end

        if (!skip_end) begin
          if (done) begin
            emit      = (type_d == wanted_q);
            emit_stat = smbsw_pkg::ST_COMPLETE;
            cnt_d     = cnt_b + 16'd1;
            start_d   = o + 16'd1;
            phase_d   = smbsw_pkg::PH_HEADER;
            armed_d   = 1'b0;
            lzero_d   = 1'b0;
          end else if (({1'b0, o} + 17'd1) == {1'b0, tlen_q}) begin
            emit      = (type_d == wanted_q);
            emit_stat = smbsw_pkg::ST_TRUNCATED;
            phase_d   = smbsw_pkg::PH_STOPPED;
          end
        end
      end
    end

    if (in_fire && emit) begin
      ovalid_d = 1'b1;
    end else if (m_axis_tready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= '0;
      tlen_q   <= '0;
      limit_q  <= '0;
      off_q    <= '0;
      start_q  <= '0;
      cnt_q    <= '0;
      phase_q  <= smbsw_pkg::PH_HEADER;
      type_q   <= '0;
      len_q    <= '0;
      handle_q <= '0;
      fleft_q  <= '0;
      lzero_q  <= 1'b0;
      armed_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          smbsw_pkg::REG_WANTED_TYPE:  wanted_q <= cfg_data_i[7:0];
          smbsw_pkg::REG_TABLE_LENGTH: tlen_q   <= cfg_data_i;
          smbsw_pkg::REG_STRUCT_LIMIT: limit_q  <= cfg_data_i;
          default: ;
        endcase
      end
      off_q    <= off_d;
      start_q  <= start_d;
      cnt_q    <= cnt_d;
      phase_q  <= phase_d;
      type_q   <= type_d;
      len_q    <= len_d;
      handle_q <= handle_d;
      fleft_q  <= fleft_d;
      lzero_q  <= lzero_d;
      armed_q  <= armed_d;
      ovalid_q <= ovalid_d;
    end
  end

  // report payload, loaded with the beat that produces it
  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      ostat_q <= emit_stat;
      odata_q <= {cnt_b, start_b, handle_d, len_d, type_d};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ostat_q;

endmodule

// ----- hdl/smbsw_checker.sv -----
// Port-level checks for the SMBIOS structure walker, bound to the top level.
`include "smbios_structure_walker_macros.svh"

module smbsw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // a stalled report keeps its contents
  `SMBSW_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // an empty output register never blocks the byte stream
  `SMBSW_ASSERT_IMP(a_empty_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

  // a broken entry is one whose formatted length is below the header size
  `SMBSW_ASSERT_IMP(a_broken_len, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser == smbsw_pkg::ST_BROKEN,
    m_axis_tdata[15:8] < 8'(smbsw_pkg::HdrBytes))

  // a complete structure went through its full header
  `SMBSW_ASSERT_IMP(a_complete_len, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tuser == smbsw_pkg::ST_COMPLETE,
    m_axis_tdata[15:8] >= 8'(smbsw_pkg::HdrBytes))

endmodule

bind smbios_structure_walker smbsw_checker u_smbsw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
